FILE: design/assert_macros.svh
// assertion macros shared by the power sense qualifier modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on clk and held off during reset
`define PSQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("psq assertion failed");

// next-cycle implication, checked on clk and held off during reset
`define PSQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("psq assertion failed");

`endif

FILE: design/psq_pkg.sv
// shared types and constants of the power sense qualifier
package psq_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int TIME_W     = 24;
	localparam int CONFIRM_W  = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_HIGH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_LOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_READS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_MS    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT_MS   = 3'd4;

	// reset values of the configuration registers
	localparam logic [SAMPLE_W-1:0]  THRESHOLD_HIGH_RST = 12'd2500;
	localparam logic [SAMPLE_W-1:0]  THRESHOLD_LOW_RST  = 12'd1500;
	localparam logic [CONFIRM_W-1:0] CONFIRM_READS_RST  = 4'd2;
	localparam logic [TIME_W-1:0]    COOLDOWN_MS_RST    = 24'd5000;
	localparam logic [TIME_W-1:0]    HEARTBEAT_MS_RST   = 24'd300000;

	typedef enum logic [1:0] {
		REPORT_NONE      = 2'd0,
		REPORT_INITIAL   = 2'd1,
		REPORT_CHANGE    = 2'd2,
		REPORT_HEARTBEAT = 2'd3
	} report_t;

	// one beat leaving the averaging pipeline
	typedef struct packed {
		logic                tick;
		logic                done;
		logic [SAMPLE_W-1:0] average;
	} avg_beat_t;

endpackage

FILE: design/psq_if.sv
// stream interfaces of the power sense qualifier

interface psq_in_if;
	import psq_pkg::*;

	logic                valid;
	logic                ready;
	logic                kind;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, output kind, output sample, input ready);
	modport sink (input valid, input kind, input sample, output ready);
endinterface

interface psq_out_if;
	import psq_pkg::*;

	logic                valid;
	logic                ready;
	logic                power_on;
	logic                status_known;
	logic [SAMPLE_W-1:0] average;
	logic                pending_change;
	logic [1:0]          report;

	modport source (output valid, output power_on, output status_known, output average,
		output pending_change, output report, input ready);
	modport sink (input valid, input power_on, input status_known, input average,
		input pending_change, input report, output ready);
endinterface

FILE: design/psq_avg.sv
// sample accumulator and reciprocal-multiply averaging pipeline
module psq_avg #(
	parameter int AVG_SAMPLES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	psq_in_if.sink              item,
	output logic                beat_valid,
	input  logic                beat_ready,
	output psq_pkg::avg_beat_t  beat
);
	import psq_pkg::*;

	`include "assert_macros.svh"

	localparam int IDX_W   = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;
	localparam int SUM_W   = SAMPLE_W + IDX_W;
	localparam int RECIP_K = SUM_W + IDX_W;
	localparam int PROD_W  = SUM_W + RECIP_K + 1;
	// ceiling reciprocal, exact for every sum below 2**SUM_W
	localparam logic [RECIP_K:0] RECIP =
		(RECIP_K+1)'(((2 ** RECIP_K) + AVG_SAMPLES - 1) / AVG_SAMPLES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(AVG_SAMPLES - 1);

	logic [SUM_W-1:0]  sum_q;
	logic [IDX_W-1:0]  idx_q;
	logic [SUM_W-1:0]  sum_next;
	logic              last_sample;
	logic              accept;

	logic              v_s1;
	logic              tick_s1;
	logic              done_s1;
	logic [SUM_W-1:0]  gsum_s1;
	logic              v_s2;
	avg_beat_t         beat_s2;

	logic              rdy_s1;
	logic              rdy_s2;
	logic [PROD_W-1:0] prod;

	assign rdy_s2     = !v_s2 || beat_ready;
	assign rdy_s1     = !v_s1 || rdy_s2;
	assign item.ready = rdy_s1;
	assign accept     = item.valid && rdy_s1;

	assign sum_next    = sum_q + SUM_W'(item.sample);
	assign last_sample = (idx_q == LAST_IDX);

	// accumulate on an accepted sample (not a tick), hand the full group sum to stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			idx_q <= '0;
		end else if (accept && !item.kind) begin
			if (last_sample) begin
				sum_q <= '0;
				idx_q <= '0;
			end else begin
				sum_q <= sum_next;
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tick_s1 <= item.kind;
			done_s1 <= !item.kind && last_sample;
			gsum_s1 <= sum_next;
		end
	end

	assign prod = {{(RECIP_K+1){1'b0}}, gsum_s1} * {{SUM_W{1'b0}}, RECIP};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			beat_s2.tick    <= tick_s1;
			beat_s2.done    <= done_s1;
			beat_s2.average <= prod[RECIP_K +: SAMPLE_W];
		end
	end

	assign beat_valid = v_s2;
	assign beat       = beat_s2;

	`PSQ_ASSERT_NOW(a_idx_range, 1'b1, idx_q <= LAST_IDX)
	`PSQ_ASSERT_NEXT(a_group_clears, accept && !item.kind && last_sample, sum_q == '0)
	`PSQ_ASSERT_NEXT(a_s2_holds, v_s2 && !beat_ready, v_s2 && $stable(beat_s2))
	`PSQ_ASSERT_NOW(a_tick_no_done, v_s1 && tick_s1, !done_s1)

endmodule

FILE: design/power_sense_qualifier.sv
// power sense qualifier: averaging, hysteresis, confirm debounce, cooldown and heartbeat
// the accumulate, multiply and qualify registers lie between an accepted beat and its result beat
// throughput: one beat per cycle while result.ready holds; the status state updates once per result in a single pass
// the averaging divide is a constant reciprocal multiply with its own pipeline stage
// reset (arst_n, async, active low) loads the default config and clears all status state
module power_sense_qualifier #(
	parameter int AVG_SAMPLES = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	psq_in_if.sink                            item,
	psq_out_if.source                         result,
	input  logic                              cfg_we,
	input  logic [psq_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [psq_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import psq_pkg::*;

	`include "assert_macros.svh"

	localparam logic [TIME_W-1:0]    TIME_MAX    = '1;
	localparam logic [CONFIRM_W-1:0] CONFIRM_MAX = '1;

	// configuration registers
	logic [SAMPLE_W-1:0]  thr_high_q;
	logic [SAMPLE_W-1:0]  thr_low_q;
	logic [CONFIRM_W-1:0] confirm_q;
	logic [TIME_W-1:0]    cooldown_q;
	logic [TIME_W-1:0]    heartbeat_q;

	// qualifier state, which doubles as the result register
	logic                 out_valid_q;
	logic                 known_q;
	logic                 status_q;
	logic                 pend_valid_q;
	logic                 pend_value_q;
	logic [CONFIRM_W-1:0] cnt_q;
	logic [SAMPLE_W-1:0]  last_avg_q;
	logic [TIME_W-1:0]    ms_rep_q;
	logic [TIME_W-1:0]    ms_hb_q;
	report_t              report_q;

	// next-state values
	logic                 known_d;
	logic                 status_d;
	logic                 pend_valid_d;
	logic                 pend_value_d;
	logic [CONFIRM_W-1:0] cnt_d;
	logic [SAMPLE_W-1:0]  last_avg_d;
	logic [TIME_W-1:0]    ms_rep_d;
	logic [TIME_W-1:0]    ms_hb_d;
	report_t              report_d;

	logic                 resolved;
	logic [CONFIRM_W-1:0] cnt_new;
	logic [TIME_W-1:0]    ms_rep_inc;
	logic [TIME_W-1:0]    ms_hb_inc;

	// averaging pipeline hand-off
	logic                 beat_valid;
	logic                 beat_ready;
	avg_beat_t            beat;
	logic                 load;

	psq_avg #(
		.AVG_SAMPLES (AVG_SAMPLES)
	) u_avg (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.beat_valid (beat_valid),
		.beat_ready (beat_ready),
		.beat       (beat)
	);

	// config writes are to land only while idle, so no hazard with in-flight beats; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_high_q  <= THRESHOLD_HIGH_RST;
			thr_low_q   <= THRESHOLD_LOW_RST;
			confirm_q   <= CONFIRM_READS_RST;
			cooldown_q  <= COOLDOWN_MS_RST;
			heartbeat_q <= HEARTBEAT_MS_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_THRESHOLD_HIGH: thr_high_q  <= cfg_data[SAMPLE_W-1:0];
				REG_THRESHOLD_LOW:  thr_low_q   <= cfg_data[SAMPLE_W-1:0];
				REG_CONFIRM_READS:  confirm_q   <= cfg_data[CONFIRM_W-1:0];
				REG_COOLDOWN_MS:    cooldown_q  <= cfg_data[TIME_W-1:0];
				REG_HEARTBEAT_MS:   heartbeat_q <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// output register frees up when empty or when its beat is taken
	assign beat_ready = !out_valid_q || result.ready;
	assign load       = beat_valid && beat_ready;

	// saturating elapsed-time counters
	assign ms_rep_inc = (ms_rep_q == TIME_MAX) ? TIME_MAX : ms_rep_q + 1'b1;
	assign ms_hb_inc  = (ms_hb_q == TIME_MAX) ? TIME_MAX : ms_hb_q + 1'b1;

	// hysteresis: high compare first so on wins on overlapping thresholds
	always_comb begin
		if (beat.average >= thr_high_q) begin
			resolved = 1'b1;
		end else if (beat.average <= thr_low_q) begin
			resolved = 1'b0;
		end else begin
			resolved = known_q ? status_q : 1'b1;
		end
	end

	// repeat count toward confirmation, restarts on a new differing value
	assign cnt_new = (pend_valid_q && pend_value_q == resolved)
		? ((cnt_q == CONFIRM_MAX) ? cnt_q : cnt_q + 1'b1)
		: CONFIRM_W'(1);

	always_comb begin
		known_d      = known_q;
		status_d     = status_q;
		pend_valid_d = pend_valid_q;
		pend_value_d = pend_value_q;
		cnt_d        = cnt_q;
		last_avg_d   = last_avg_q;
		ms_rep_d     = ms_rep_q;
		ms_hb_d      = ms_hb_q;
		report_d     = REPORT_NONE;
		if (beat.tick) begin
			ms_rep_d = ms_rep_inc;
			ms_hb_d  = ms_hb_inc;
			// no heartbeat until the status is known
			if (known_q && ms_hb_inc >= heartbeat_q) begin
				ms_rep_d = '0;
				ms_hb_d  = '0;
				report_d = REPORT_HEARTBEAT;
			end
		end else if (beat.done) begin
			last_avg_d = beat.average;
			if (!known_q) begin
				// first average sets the status outright
				status_d     = resolved;
				known_d      = 1'b1;
				pend_valid_d = 1'b0;
				pend_value_d = 1'b0;
				cnt_d        = '0;
				ms_rep_d     = '0;
				ms_hb_d      = '0;
				report_d     = REPORT_INITIAL;
			end else if (resolved == status_q) begin
				pend_valid_d = 1'b0;
				pend_value_d = 1'b0;
				cnt_d        = '0;
			end else if (cnt_new >= confirm_q) begin
				// confirmed; reported only once the cooldown has run out
				status_d     = resolved;
				pend_valid_d = 1'b0;
				pend_value_d = 1'b0;
				cnt_d        = '0;
				if (ms_rep_q >= cooldown_q) begin
					ms_rep_d = '0;
					report_d = REPORT_CHANGE;
				end
			end else begin
				pend_valid_d = 1'b1;
				pend_value_d = resolved;
				cnt_d        = cnt_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			known_q      <= 1'b0;
			status_q     <= 1'b0;
			pend_valid_q <= 1'b0;
			pend_value_q <= 1'b0;
			cnt_q        <= '0;
			last_avg_q   <= '0;
			ms_rep_q     <= '0;
			ms_hb_q      <= '0;
			report_q     <= REPORT_NONE;
		end else begin
			if (beat_ready) begin
				out_valid_q <= beat_valid;
			end
			if (load) begin
				known_q      <= known_d;
				status_q     <= status_d;
				pend_valid_q <= pend_valid_d;
				pend_value_q <= pend_value_d;
				cnt_q        <= cnt_d;
				last_avg_q   <= last_avg_d;
				ms_rep_q     <= ms_rep_d;
				ms_hb_q      <= ms_hb_d;
				report_q     <= report_d;
			end
		end
	end

	// result beat comes straight from the state registers
	assign result.valid          = out_valid_q;
	assign result.power_on       = known_q && status_q;
	assign result.status_known   = known_q;
	assign result.average        = last_avg_q;
	assign result.pending_change = pend_valid_q;
	assign result.report         = report_q;

	`PSQ_ASSERT_NOW(a_pend_needs_known, pend_valid_q, known_q)
	`PSQ_ASSERT_NOW(a_pend_count, 1'b1, pend_valid_q == (cnt_q != '0))
	`PSQ_ASSERT_NEXT(a_hb_clears, load && report_d == REPORT_HEARTBEAT,
		ms_hb_q == '0 && ms_rep_q == '0)
	`PSQ_ASSERT_NEXT(a_stall_holds, out_valid_q && !result.ready,
		out_valid_q && $stable(report_q) && $stable(last_avg_q))

endmodule
